// ----- rtl/ps2_host_byte_transceiver_core_macros.svh -----
// ---------------------------------------------------------------------------
// PS/2 host transceiver assertion macros
// Shared property forms for the checker of the PS/2 host transceiver.
// ---------------------------------------------------------------------------
`ifndef PS2_HOST_BYTE_TRANSCEIVER_CORE_MACROS_SVH
`define PS2_HOST_BYTE_TRANSCEIVER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define PS2HT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ps2ht check failed");

// Next-cycle implication, off while reset is high.
`define PS2HT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ps2ht check failed");

// Next-cycle implication that also runs through reset.
`define PS2HT_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ps2ht check failed");

`endif

// ----- rtl/ps2ht_pkg.sv -----
// ---------------------------------------------------------------------------
// PS/2 host transceiver package
// Shared types, codes and constants of the PS/2 host transceiver.
// ---------------------------------------------------------------------------
package ps2ht_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int CFG_W             = 16;
  localparam int CFG_IDX_W         = 2;
  localparam int CMD_W             = 2;
  localparam int BYTE_W            = 8;
  localparam int FRAME_BITS        = 11;
  localparam int BIT_CNT_W         = 4;
  localparam int IN_TDATA_W        = 16;
  localparam int OUT_TDATA_W       = 16;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RECV = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REQ_HOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_PAUSE   = 2'd2;

  localparam logic [CFG_W-1:0] REQ_HOLD_RST   = 16'd100;
  localparam logic [CFG_W-1:0] RX_RELEASE_RST = 16'd50;
  localparam logic [CFG_W-1:0] RX_PAUSE_RST   = 16'd100;

  localparam logic [BIT_CNT_W-1:0] LAST_TX_BIT = 4'd9;
  localparam logic [BIT_CNT_W-1:0] FRAME_LEN   = 4'd11;
  localparam logic [BYTE_W-1:0]    ERR_BYTE    = 8'hFF;

  typedef struct packed {
    logic [CFG_W-1:0] req_hold;
    logic [CFG_W-1:0] rx_release;
    logic [CFG_W-1:0] rx_pause;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] send_byte;
    logic              clock_line;
    logic              data_line;
  } item_t;

  typedef struct packed {
    logic              frame_error;
    logic [BYTE_W-1:0] received_byte;
    logic              received_valid;
    logic              send_done;
    logic              busy_res;
    logic              data_pull_low;
    logic              clock_pull_low;
  } result_t;

endpackage

// ----- rtl/ps2ht_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// PS/2 host transceiver configuration registers
// Holds the three tick counts written over the configuration channel.
// ---------------------------------------------------------------------------
module ps2ht_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ps2ht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ps2ht_pkg::CFG_W-1:0]      cfg_data,
  output ps2ht_pkg::cfg_t                  cfg
);
  import ps2ht_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.req_hold   <= REQ_HOLD_RST;
      cfg.rx_release <= RX_RELEASE_RST;
      cfg.rx_pause   <= RX_PAUSE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REQ_HOLD:   cfg.req_hold   <= cfg_data;
        CFG_RX_RELEASE: cfg.rx_release <= cfg_data;
        CFG_RX_PAUSE:   cfg.rx_pause   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/ps2ht_engine.sv -----
// ---------------------------------------------------------------------------
// PS/2 host transceiver link engine
// Advances the link state machine by one sample tick per step and forms
// the result of that tick.
// ---------------------------------------------------------------------------
module ps2ht_engine #(
  parameter int COUNTER_WIDTH = ps2ht_pkg::COUNTER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  ps2ht_pkg::item_t   item,
  input  ps2ht_pkg::cfg_t    cfg,
  output ps2ht_pkg::result_t result
);
  import ps2ht_pkg::*;

  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_REQ_HOLD     = 4'd1;
  localparam logic [3:0] PH_TX_START     = 4'd2;
  localparam logic [3:0] PH_TX_BITS      = 4'd3;
  localparam logic [3:0] PH_TX_ACK_DATA  = 4'd4;
  localparam logic [3:0] PH_TX_ACK_CLOCK = 4'd5;
  localparam logic [3:0] PH_TX_IDLE_WAIT = 4'd6;
  localparam logic [3:0] PH_RX_RELEASE   = 4'd7;
  localparam logic [3:0] PH_RX_LOW       = 4'd8;
  localparam logic [3:0] PH_RX_HIGH      = 4'd9;
  localparam logic [3:0] PH_RX_PAUSE     = 4'd10;

  logic [3:0]               phase, phase_next;
  logic [BIT_CNT_W-1:0]     bit_count, bit_count_next;
  logic [FRAME_BITS-1:0]    frame_shift, frame_shift_next;
  logic [COUNTER_WIDTH-1:0] wait_counter, wait_counter_next;
  logic [COUNTER_WIDTH-1:0] wait_dec;
  logic                     prev_clock;
  logic                     finish;
  logic                     done;
  logic                     parity;

  assign parity   = ~(^item.send_byte);
  assign wait_dec = (wait_counter != '0) ? wait_counter - COUNTER_WIDTH'(1) : wait_counter;

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    frame_shift_next  = frame_shift;
    wait_counter_next = wait_counter;
    finish            = 1'b0;
    done              = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (item.command == CMD_SEND) begin
          frame_shift_next  = {1'b1, parity, item.send_byte, 1'b0};
          bit_count_next    = '0;
          wait_counter_next = COUNTER_WIDTH'(cfg.req_hold);
          phase_next = (wait_counter_next == '0) ? PH_TX_START : PH_REQ_HOLD;
        end else if (item.command == CMD_RECV) begin
          frame_shift_next  = '0;
          bit_count_next    = '0;
          wait_counter_next = COUNTER_WIDTH'(cfg.rx_release);
          phase_next = (wait_counter_next == '0) ? PH_RX_LOW : PH_RX_RELEASE;
        end
      end
      PH_REQ_HOLD: begin
        wait_counter_next = wait_dec;
        if (wait_dec == '0) phase_next = PH_TX_START;
      end
      PH_TX_START: begin
        if (!item.clock_line) begin
          phase_next     = PH_TX_BITS;
          bit_count_next = BIT_CNT_W'(1);
        end
      end
      PH_TX_BITS: begin
        if (prev_clock && !item.clock_line) begin
          if (bit_count >= LAST_TX_BIT) phase_next = PH_TX_ACK_DATA;
          else bit_count_next = bit_count + BIT_CNT_W'(1);
        end
      end
      PH_TX_ACK_DATA: begin
        if (!item.data_line) phase_next = PH_TX_ACK_CLOCK;
      end
      PH_TX_ACK_CLOCK: begin
        if (!item.clock_line) phase_next = PH_TX_IDLE_WAIT;
      end
      PH_TX_IDLE_WAIT: begin
        if (item.clock_line && item.data_line) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
      PH_RX_RELEASE: begin
        wait_counter_next = wait_dec;
        if (wait_dec == '0) phase_next = PH_RX_LOW;
      end
      PH_RX_LOW: begin
        if (!item.clock_line) begin
          if (bit_count < FRAME_LEN) begin
            if (item.data_line) begin
              frame_shift_next = frame_shift | (FRAME_BITS'(1) << bit_count);
            end
            bit_count_next = bit_count + BIT_CNT_W'(1);
          end
          phase_next = PH_RX_HIGH;
        end
      end
      PH_RX_HIGH: begin
        if (item.clock_line) begin
          if (bit_count >= FRAME_LEN) begin
            wait_counter_next = COUNTER_WIDTH'(cfg.rx_pause);
            if (wait_counter_next == '0) finish = 1'b1;
            else phase_next = PH_RX_PAUSE;
          end else begin
            phase_next = PH_RX_LOW;
          end
        end
      end
      PH_RX_PAUSE: begin
        wait_counter_next = wait_dec;
        if (wait_dec == '0) finish = 1'b1;
      end
      default: phase_next = PH_IDLE;
    endcase
    if (finish) phase_next = PH_IDLE;
  end

  always_comb begin
    result                = '0;
    result.send_done      = done;
    result.received_valid = finish;
    result.busy_res       = (phase_next != PH_IDLE);
    if (finish) begin
      if (!frame_shift_next[0] && frame_shift_next[FRAME_BITS-1]) begin
        result.received_byte = frame_shift_next[BYTE_W:1];
      end else begin
        result.received_byte = ERR_BYTE;
        result.frame_error   = 1'b1;
      end
    end
    result.clock_pull_low = (phase_next == PH_REQ_HOLD) || (phase_next == PH_RX_PAUSE);
    if (phase_next == PH_TX_START) begin
      result.data_pull_low = 1'b1;
    end else if (phase_next == PH_TX_BITS && bit_count_next < FRAME_LEN) begin
      result.data_pull_low = ~frame_shift_next[bit_count_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      frame_shift  <= '0;
      wait_counter <= '0;
      prev_clock   <= 1'b1;
    end else if (step) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      frame_shift  <= frame_shift_next;
      wait_counter <= wait_counter_next;
      prev_clock   <= item.clock_line;
    end
  end

endmodule

// ----- rtl/ps2ht_out_buffer.sv -----
// ---------------------------------------------------------------------------
// PS/2 host transceiver result buffer
// Output register with a skid stage for the result stream.
// ---------------------------------------------------------------------------
module ps2ht_out_buffer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               push_ready,
  input  logic [ps2ht_pkg::OUT_TDATA_W-1:0]  push_data,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ps2ht_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import ps2ht_pkg::*;

  logic                   skid_valid;
  logic [OUT_TDATA_W-1:0] skid_data;
  logic                   pop;

  assign push_ready = !skid_valid;
  assign pop        = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!m_tvalid || pop) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) m_tdata <= skid_data;
    end else if (push) begin
      if (!m_tvalid || pop) m_tdata <= push_data;
      else skid_data <= push_data;
    end
  end

endmodule

// ----- rtl/ps2_host_byte_transceiver_core.sv -----
// ---------------------------------------------------------------------------
// PS/2 host byte transceiver core
// Host side of a PS/2 link: sends and receives bytes over open-drain clock
// and data lines, one line-sample transaction per tick.
// ---------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  s_*      in   s_tvalid / s_tready   sample tick: command, byte, line levels
//  m_*      out  m_tvalid / m_tready   line drives, status, received byte
//  cfg_*    in   cfg_valid / cfg_ready register index and 16-bit value
//
//  One result transaction per input transaction, one input per cycle while the skid stage is empty.
//  Each input passes through the input register and then the result register.
//  The link state machine advances when the input register hands to the
//  result buffer; a stalled output fills the skid stage, then stalls input.
//  Reset is synchronous; the result stream is empty after reset.
// ---------------------------------------------------------------------------
module ps2_host_byte_transceiver_core #(
  parameter int COUNTER_WIDTH = ps2ht_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [7:0] send_byte, [8] clock_line, [9] data_line, [15:10] zero
  input  logic [ps2ht_pkg::IN_TDATA_W-1:0]   s_tdata,
  // [1:0] command
  input  logic [ps2ht_pkg::CMD_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] clock_pull_low, [1] data_pull_low, [2] busy_res, [3] send_done,
  // [4] received_valid, [12:5] received_byte, [13] frame_error, [15:14] zero
  output logic [ps2ht_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ps2ht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ps2ht_pkg::CFG_W-1:0]        cfg_data
);
  import ps2ht_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t result;
  logic    item_valid;
  logic    buf_ready;
  logic    advance;

  assign advance  = item_valid && buf_ready;
  assign s_tready = !item_valid || buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.command    <= s_tuser;
      item.send_byte  <= s_tdata[BYTE_W-1:0];
      item.clock_line <= s_tdata[BYTE_W];
      item.data_line  <= s_tdata[BYTE_W+1];
    end
  end

  ps2ht_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ps2ht_engine #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  ps2ht_out_buffer u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (advance),
    .push_ready (buf_ready),
    .push_data  ({2'b00, result}),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// ----- rtl/ps2ht_checker.sv -----
// ---------------------------------------------------------------------------
// PS/2 host transceiver port checker
// Watches the result stream port of the transceiver core for illegal results.
// ---------------------------------------------------------------------------
`include "ps2_host_byte_transceiver_core_macros.svh"

module ps2ht_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [ps2ht_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import ps2ht_pkg::*;

  logic stalled;
  logic out_end;
  logic out_drive;

  assign stalled   = m_tvalid && !m_tready;
  assign out_end   = m_tvalid && (m_tdata[3] || m_tdata[4]);
  assign out_drive = m_tdata[2] || m_tdata[1] || m_tdata[0];

  `PS2HT_ASSERT_NXT_ALWAYS(a_empty_after_reset, clk, rst, !m_tvalid)
  `PS2HT_ASSERT_NXT(a_hold_on_stall, clk, rst, stalled, m_tvalid && $stable(m_tdata))
  `PS2HT_ASSERT_IMP(a_quiet_without_rx, clk, rst, m_tvalid && !m_tdata[4], m_tdata[13:5] == 9'd0)
  `PS2HT_ASSERT_IMP(a_error_byte, clk, rst, m_tvalid && m_tdata[13], m_tdata[12:5] == ERR_BYTE)
  `PS2HT_ASSERT_IMP(a_done_is_idle, clk, rst, out_end, !out_drive)

endmodule

bind ps2_host_byte_transceiver_core ps2ht_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
